@@ design/psm_pkg.sv @@
// Shared types and constants of the polyphonic sample mixer.
package psm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_QUEUE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam int POS_W   = 17;
  localparam int START_W = 16;
  localparam int SMP_W   = 16;
  localparam int CNT_W   = 5;

  typedef struct packed {
    logic [1:0]              command;
    logic [START_W-1:0]      address;
    logic signed [SMP_W-1:0] sample_value;
    logic [POS_W-1:0]        sound_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] mixed_sample;
    logic [CNT_W-1:0]        voices_active;
  } out_item_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [POS_W-1:0]   length;
    logic [POS_W-1:0]   position;
  } voice_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUEUE,
    ST_TICK,
    ST_DONE
  } state_t;

endpackage

@@ design/psm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/psm_mix_acc.sv @@
// Saturating mix accumulator and busy-voice counter shared by all slots.
module psm_mix_acc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psm_pkg::acc_ctrl_t              ctrl,
  input  logic signed [psm_pkg::SMP_W-1:0] sample,
  output logic signed [psm_pkg::SMP_W-1:0] sum,
  output logic [psm_pkg::CNT_W-1:0]        count
);
  import psm_pkg::*;

  logic signed [SMP_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SMP_W:0]   wide;

  always_comb begin
    wide      = {sum_r[SMP_W-1], sum_r} + {sample[SMP_W-1], sample};
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      sum_nxt   = '0;
      count_nxt = '0;
    end else if (ctrl.add) begin
      if (wide[SMP_W] != wide[SMP_W-1]) begin
        // overflow: clamp towards the sign of the true sum
        sum_nxt = wide[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
      end else begin
        sum_nxt = wide[SMP_W-1:0];
      end
      if (count_r != {CNT_W{1'b1}}) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  assign sum   = sum_r;
  assign count = count_r;

endmodule

@@ design/polyphonic_sample_mixer.sv @@
// Top level of the polyphonic sample mixer: slot sequencer, voice and sample memories.
//
//   channel | direction | handshake           | payload
//   in_     | in        | in_valid / in_stall | in_item  (command, address, value, length)
//   out_    | out       | out_valid/out_stall | out_item (mixed_sample, voices_active)
//
// Queue: one voice slot looked at per cycle. Tick: slots walk through the voice RAM read,
// the sample RAM read and the one saturating adder, then the result is loaded.
// A tick waits in its last step while a previous result is still stalled.
// Reset clears all voices; sample memory holds nothing defined until written.
// in_stall is high whenever a queue or tick item is still being worked on.
module polyphonic_sample_mixer #(
  parameter int VOICES       = 30,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output psm_pkg::out_item_t out_item
);
  import psm_pkg::*;

  // SAMPLE_DEPTH is taken to be a power of two
  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int SLW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PW  = $clog2(VOICES + 2);
  localparam int WAW = (AW > START_W) ? AW : START_W;
  localparam int SW  = (AW > 18) ? AW : 18;
  localparam int VW  = $bits(voice_t);

  state_t              state_r, state_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic [VOICES-1:0]   busy_r, busy_nxt;
  logic                p1_v_r, p1_v_nxt;
  logic [SLW-1:0]      p1_slot_r, p1_slot_nxt;
  logic                p2_v_r, p2_v_nxt;
  logic [START_W-1:0]  qaddr_r, qaddr_nxt;
  logic [POS_W-1:0]    qlen_r, qlen_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                in_accept;
  logic [SLW-1:0]      slot_a;
  voice_t              vrd, vwr;
  logic                vram_we;
  logic [SLW-1:0]      vram_waddr;
  logic [VW-1:0]       vram_rdata;
  logic                sram_we;
  logic [WAW-1:0]      waddr_wide;
  logic [SW-1:0]       raddr_wide;
  logic [SMP_W-1:0]    sram_rdata;
  logic [POS_W-1:0]    pos_inc;
  logic                voice_end;
  acc_ctrl_t           acc_ctrl;
  logic signed [SMP_W-1:0] acc_sum;
  logic [CNT_W-1:0]    acc_count;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign slot_a     = ptr_r[SLW-1:0];
  assign vrd        = voice_t'(vram_rdata);
  assign sram_we    = in_accept && (in_item.command == CMD_WRITE);
  assign waddr_wide = WAW'(in_item.address);
  assign raddr_wide = SW'(vrd.start) + SW'(vrd.position);
  assign pos_inc    = vrd.position + POS_W'(1);
  assign voice_end  = (pos_inc == '0) || (pos_inc >= vrd.length);

  psm_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vwr),
    .raddr (slot_a),
    .rdata (vram_rdata)
  );

  psm_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (waddr_wide[AW-1:0]),
    .wdata (in_item.sample_value),
    .raddr (raddr_wide[AW-1:0]),
    .rdata (sram_rdata)
  );

  psm_mix_acc u_mix_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .sample (signed'(sram_rdata)),
    .sum    (acc_sum),
    .count  (acc_count)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    busy_nxt      = busy_r;
    p1_v_nxt      = 1'b0;
    p1_slot_nxt   = p1_slot_r;
    p2_v_nxt      = p1_v_r;
    qaddr_nxt     = qaddr_r;
    qlen_nxt      = qlen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    vram_we       = 1'b0;
    vram_waddr    = p1_slot_r;
    vwr           = vrd;
    acc_ctrl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_item.command)
            CMD_QUEUE: begin
              if (in_item.sound_length != '0) begin
                qaddr_nxt = in_item.address;
                qlen_nxt  = in_item.sound_length;
                ptr_nxt   = '0;
                state_nxt = ST_QUEUE;
              end
            end
            CMD_TICK: begin
              ptr_nxt        = '0;
              acc_ctrl.clear = 1'b1;
              state_nxt      = ST_TICK;
            end
            default: ;
          endcase
        end
      end
      ST_QUEUE: begin
        if (!busy_r[slot_a]) begin
          vram_we          = 1'b1;
          vram_waddr       = slot_a;
          vwr.start        = qaddr_r;
          vwr.length       = qlen_r;
          vwr.position     = '0;
          busy_nxt[slot_a] = 1'b1;
          state_nxt        = ST_IDLE;
        end else if (ptr_r == PW'(VOICES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      ST_TICK: begin
        ptr_nxt = ptr_r + PW'(1);
        if (ptr_r < PW'(VOICES)) begin
          p1_v_nxt    = busy_r[slot_a];
          p1_slot_nxt = slot_a;
        end
        if (p1_v_r) begin
          vram_we      = 1'b1;
          vwr.position = voice_end ? '0 : pos_inc;
          if (voice_end) begin
            busy_nxt[p1_slot_r] = 1'b0;
          end
        end
        if (p2_v_r) begin
          acc_ctrl.add = 1'b1;
        end
        if (ptr_r == PW'(VOICES + 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.mixed_sample  = acc_sum;
          out_item_nxt.voices_active = acc_count;
          state_nxt                  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      busy_r      <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      busy_r      <= busy_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_slot_r  <= p1_slot_nxt;
    qaddr_r    <= qaddr_nxt;
    qlen_r     <= qlen_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_busy_clears_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_TICK |=> (busy_r | $past(busy_r)) == busy_r)
    else $error("voice freed outside a tick");

  a_one_slot_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> $countones(busy_r ^ $past(busy_r)) <= 1)
    else $error("more than one voice slot changed in a cycle");

  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r || p2_v_r) |-> state_r == ST_TICK)
    else $error("slot pipeline active outside a tick");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && out_stall |=> state_r == ST_DONE)
    else $error("tick result overwrote a stalled item");

endmodule
